// File: design/oale_pkg.sv
// Package for the ordered array list engine: codes, control word and microcode table.
`timescale 1ns / 1ps
`default_nettype none

package oale_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int WORD_BITS_DEF = 32;

    localparam int FIELD_W = 32;
    localparam int EXT_W   = 64;

    localparam logic [2:0] M_APPEND = 3'd0;
    localparam logic [2:0] M_INSERT = 3'd1;
    localparam logic [2:0] M_EDIT   = 3'd2;
    localparam logic [2:0] M_DELETE = 3'd3;
    localparam logic [2:0] M_READ   = 3'd4;
    localparam logic [2:0] M_FIND   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam int UPC_W = 4;

    localparam logic [UPC_W-1:0] U_IDLE = 4'd0;
    localparam logic [UPC_W-1:0] U_DONE = 4'd1;
    localparam logic [UPC_W-1:0] U_APP  = 4'd2;
    localparam logic [UPC_W-1:0] U_INS1 = 4'd3;
    localparam logic [UPC_W-1:0] U_INS2 = 4'd4;
    localparam logic [UPC_W-1:0] U_EDT  = 4'd5;
    localparam logic [UPC_W-1:0] U_DEL1 = 4'd6;
    localparam logic [UPC_W-1:0] U_DEL2 = 4'd7;
    localparam logic [UPC_W-1:0] U_DELE = 4'd8;
    localparam logic [UPC_W-1:0] U_RD1  = 4'd9;
    localparam logic [UPC_W-1:0] U_RD2  = 4'd10;
    localparam logic [UPC_W-1:0] U_FND0 = 4'd11;
    localparam logic [UPC_W-1:0] U_FND1 = 4'd12;

    localparam logic [1:0] PTR_HOLD = 2'd0;
    localparam logic [1:0] PTR_INC  = 2'd1;
    localparam logic [1:0] PTR_DEC  = 2'd2;

    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    localparam logic [2:0] RD_PTR = 3'd0;
    localparam logic [2:0] RD_M1  = 3'd1;
    localparam logic [2:0] RD_M2  = 3'd2;
    localparam logic [2:0] RD_P1  = 3'd3;
    localparam logic [2:0] RD_P2  = 3'd4;

    localparam logic WR_VAL   = 1'b0;
    localparam logic WR_RDATA = 1'b1;

    localparam logic [2:0] C_ALWAYS     = 3'd0;
    localparam logic [2:0] C_PTR_NE_POS = 3'd1;
    localparam logic [2:0] C_PM1_NE_POS = 3'd2;
    localparam logic [2:0] C_P1_NE_CNT  = 3'd3;
    localparam logic [2:0] C_P2_NE_CNT  = 3'd4;
    localparam logic [2:0] C_CNT_ZERO   = 3'd5;
    localparam logic [2:0] C_HIT_OR_END = 3'd6;

    typedef struct packed {
        logic [1:0]       ptr_op;
        logic [1:0]       cnt_op;
        logic [2:0]       rd_sel;
        logic             wr_en;
        logic             wr_src;
        logic             rd_cap;
        logic             hit_cap;
        logic             done;
        logic [2:0]       cond;
        logic [UPC_W-1:0] jmp;
        logic [UPC_W-1:0] nxt;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [UPC_W-1:0] upc);
        ctrl_t w;
        w = '0;
        w.jmp = U_DONE;
        w.nxt = U_DONE;
        unique case (upc)
            U_DONE:
            begin
                w.done = 1'b1;
            end
            U_APP:
            begin
                w.wr_en  = 1'b1;
                w.wr_src = WR_VAL;
                w.cnt_op = CNT_INC;
            end
            U_INS1:
            begin
                w.rd_sel = RD_M1;
                w.cond   = C_PTR_NE_POS;
                w.jmp    = U_INS2;
                w.nxt    = U_APP;
            end
            U_INS2:
            begin
                w.wr_en  = 1'b1;
                w.wr_src = WR_RDATA;
                w.rd_sel = RD_M2;
                w.ptr_op = PTR_DEC;
                w.cond   = C_PM1_NE_POS;
                w.jmp    = U_INS2;
                w.nxt    = U_APP;
            end
            U_EDT:
            begin
                w.wr_en  = 1'b1;
                w.wr_src = WR_VAL;
            end
            U_DEL1:
            begin
                w.rd_sel = RD_P1;
                w.cond   = C_P1_NE_CNT;
                w.jmp    = U_DEL2;
                w.nxt    = U_DELE;
            end
            U_DEL2:
            begin
                w.wr_en  = 1'b1;
                w.wr_src = WR_RDATA;
                w.rd_sel = RD_P2;
                w.ptr_op = PTR_INC;
                w.cond   = C_P2_NE_CNT;
                w.jmp    = U_DEL2;
                w.nxt    = U_DELE;
            end
            U_DELE:
            begin
                w.cnt_op = CNT_DEC;
            end
            U_RD1:
            begin
                w.rd_sel = RD_PTR;
                w.jmp    = U_RD2;
            end
            U_RD2:
            begin
                w.rd_cap = 1'b1;
            end
            U_FND0:
            begin
                w.rd_sel = RD_PTR;
                w.ptr_op = PTR_INC;
                w.cond   = C_CNT_ZERO;
                w.nxt    = U_FND1;
            end
            U_FND1:
            begin
                w.rd_sel  = RD_PTR;
                w.ptr_op  = PTR_INC;
                w.hit_cap = 1'b1;
                w.cond    = C_HIT_OR_END;
                w.nxt     = U_FND1;
            end
            default:
            begin
                w.jmp = U_IDLE;
                w.nxt = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/oale_if.sv
// Request and response channel interfaces of the ordered array list engine.
`timescale 1ns / 1ps
`default_nettype none

interface oale_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  position;
    logic [31:0] item_value;

    modport source (output valid, output mode, output position, output item_value,
                    input ready);
    modport sink (input valid, input mode, input position, input item_value,
                  output ready);
endinterface

interface oale_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [7:0]  found_position;
    logic [5:0]  entry_total;
    logic        is_empty;
    logic        is_full;

    modport source (output valid, output status, output read_value, output found_position,
                    output entry_total, output is_empty, output is_full, input ready);
    modport sink (input valid, input status, input read_value, input found_position,
                  input entry_total, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// File: design/oale_store.sv
// Entry memory of the list: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module oale_store
    import oale_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    localparam int IDX_W    = $clog2(DEPTH)
)
(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire logic [WORD_BITS-1:0] wr_data,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output logic      [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/ordered_array_list_engine.sv
// Top level of the ordered array list engine: microcoded sequencer around the entry memory.
//
//   Channel  Direction  Transaction carries
//   req      in         mode, position, item_value
//   rsp      out        status, read_value, found_position, entry_total, is_empty, is_full
//
// Error cases go from acceptance straight to the done step, which loads the response register;
// append and edit pass through their write step first, and read through U_RD1 and U_RD2. Insert,
// delete and find walk the entry memory one entry per cycle before the done step.
// The sequencer is idle again as the response loads, so the next request can be taken from then on.
// Reset clears the entry count, the sequencer and the response valid; the memory is not cleared.
// A new request is taken whenever the sequencer is idle, even while a response waits to be taken.
// A stalled response holds the sequencer in its final step until the response register frees.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_list_engine
    import oale_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input wire logic clk,
    input wire logic rst_n,
    oale_req_if.sink   req,
    oale_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W + 1 > 8) ? CNT_W + 1 : 8;

    logic [UPC_W-1:0]     upc_reg, upc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [7:0]           pos_reg, pos_next;
    logic [WORD_BITS-1:0] val_reg, val_next;
    logic [2:0]           status_reg, status_next;
    logic [FIELD_W-1:0]   rd_reg, rd_next;
    logic [7:0]           fpos_reg, fpos_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [2:0]           out_status_reg, out_status_next;
    logic [FIELD_W-1:0]   out_rd_reg, out_rd_next;
    logic [7:0]           out_fpos_reg, out_fpos_next;
    logic [5:0]           out_total_reg, out_total_next;
    logic                 out_empty_reg, out_empty_next;
    logic                 out_full_reg, out_full_next;

    ctrl_t                cw;
    logic                 req_fire;
    logic                 out_free;
    logic                 out_load;
    logic                 is_full_now;
    logic [CMP_W-1:0]     cnt_x;
    logic [CMP_W-1:0]     ptr_x;
    logic [CMP_W-1:0]     pos_x;
    logic [CMP_W-1:0]     pos_in_x;
    logic [CMP_W-1:0]     rd_addr_x;
    logic                 hit;
    logic                 cond_true;
    logic                 mem_wr_en;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic [WORD_BITS-1:0] mem_rd_data;

    assign cw          = ucode(upc_reg);
    assign req.ready   = (upc_reg == U_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign is_full_now = (cnt_reg == CNT_W'(DEPTH));
    assign cnt_x       = CMP_W'(cnt_reg);
    assign ptr_x       = CMP_W'(ptr_reg);
    assign pos_x       = CMP_W'(pos_reg);
    assign pos_in_x    = CMP_W'(req.position);
    assign hit         = (mem_rd_data == val_reg);

    always_comb
    begin
        case (cw.cond)
            C_PTR_NE_POS: cond_true = (ptr_x != pos_x);
            C_PM1_NE_POS: cond_true = (ptr_x - CMP_W'(1) != pos_x);
            C_P1_NE_CNT:  cond_true = (ptr_x + CMP_W'(1) != cnt_x);
            C_P2_NE_CNT:  cond_true = (ptr_x + CMP_W'(2) != cnt_x);
            C_CNT_ZERO:   cond_true = (cnt_reg == '0);
            C_HIT_OR_END: cond_true = hit || (ptr_x == cnt_x);
            default:      cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        case (cw.rd_sel)
            RD_M1:   rd_addr_x = ptr_x - CMP_W'(1);
            RD_M2:   rd_addr_x = ptr_x - CMP_W'(2);
            RD_P1:   rd_addr_x = ptr_x + CMP_W'(1);
            RD_P2:   rd_addr_x = ptr_x + CMP_W'(2);
            default: rd_addr_x = ptr_x;
        endcase
    end

    assign mem_wr_en   = (upc_reg != U_IDLE) && cw.wr_en;
    assign mem_wr_data = (cw.wr_src == WR_RDATA) ? mem_rd_data : val_reg;

    oale_store #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (ptr_reg[IDX_W-1:0]),
        .wr_data (mem_wr_data),
        .rd_addr (rd_addr_x[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        upc_next        = upc_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        status_next     = status_reg;
        rd_next         = rd_reg;
        fpos_next       = fpos_reg;
        out_load        = 1'b0;

        if (upc_reg == U_IDLE)
        begin
            if (req_fire)
            begin
                pos_next    = req.position;
                val_next    = WORD_BITS'(EXT_W'(req.item_value));
                rd_next     = '0;
                fpos_next   = '0;
                status_next = ST_OK;
                ptr_next    = CNT_W'(req.position);
                upc_next    = U_DONE;
                case (req.mode)
                    M_APPEND:
                    begin
                        ptr_next = cnt_reg;
                        if (is_full_now)
                            status_next = ST_FULL;
                        else
                            upc_next = U_APP;
                    end
                    M_INSERT:
                    begin
                        ptr_next = cnt_reg;
                        if (is_full_now)
                            status_next = ST_FULL;
                        else if (pos_in_x > cnt_x)
                            status_next = ST_INVALID;
                        else
                            upc_next = U_INS1;
                    end
                    M_EDIT:
                    begin
                        if (pos_in_x >= cnt_x)
                            status_next = ST_INVALID;
                        else
                            upc_next = U_EDT;
                    end
                    M_DELETE:
                    begin
                        if (cnt_reg == '0)
                            status_next = ST_EMPTY;
                        else if (pos_in_x >= cnt_x)
                            status_next = ST_INVALID;
                        else
                            upc_next = U_DEL1;
                    end
                    M_READ:
                    begin
                        if (pos_in_x >= cnt_x)
                            status_next = ST_INVALID;
                        else
                            upc_next = U_RD1;
                    end
                    M_FIND:
                    begin
                        ptr_next    = '0;
                        status_next = ST_NOT_FOUND;
                        upc_next    = U_FND0;
                    end
                    default:
                    begin
                        upc_next = U_DONE;
                    end
                endcase
            end
        end
        else if (cw.done)
        begin
            if (out_free)
            begin
                out_load = 1'b1;
                upc_next = U_IDLE;
            end
        end
        else
        begin
            upc_next = cond_true ? cw.jmp : cw.nxt;
            case (cw.ptr_op)
                PTR_INC: ptr_next = ptr_reg + CNT_W'(1);
                PTR_DEC: ptr_next = ptr_reg - CNT_W'(1);
                default: ptr_next = ptr_reg;
            endcase
            case (cw.cnt_op)
                CNT_INC: cnt_next = cnt_reg + CNT_W'(1);
                CNT_DEC: cnt_next = cnt_reg - CNT_W'(1);
                default: cnt_next = cnt_reg;
            endcase
            if (cw.rd_cap)
                rd_next = FIELD_W'(EXT_W'(mem_rd_data));
            if (cw.hit_cap && hit)
            begin
                status_next = ST_OK;
                fpos_next   = 8'(ptr_x - CMP_W'(1));
            end
        end
    end

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_rd_next     = out_rd_reg;
        out_fpos_next   = out_fpos_reg;
        out_total_next  = out_total_reg;
        out_empty_next  = out_empty_reg;
        out_full_next   = out_full_reg;
        if (out_load)
        begin
            rsp_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_rd_next     = rd_reg;
            out_fpos_next   = fpos_reg;
            out_total_next  = 6'(cnt_reg);
            out_empty_next  = (cnt_reg == '0);
            out_full_next   = is_full_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= U_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        status_reg     <= status_next;
        rd_reg         <= rd_next;
        fpos_reg       <= fpos_next;
        out_status_reg <= out_status_next;
        out_rd_reg     <= out_rd_next;
        out_fpos_reg   <= out_fpos_next;
        out_total_reg  <= out_total_next;
        out_empty_reg  <= out_empty_next;
        out_full_reg   <= out_full_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.read_value     = out_rd_reg;
    assign rsp.found_position = out_fpos_reg;
    assign rsp.entry_total    = out_total_reg;
    assign rsp.is_empty       = out_empty_reg;
    assign rsp.is_full        = out_full_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the list depth.");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (upc_reg != U_IDLE))
        else $error("Accepted transaction did not start the sequencer.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!rsp_valid_reg || rsp.ready))
        else $error("Response register loaded while holding an untaken response.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg != U_IDLE) |=> (cnt_reg == $past(cnt_reg)
            || cnt_reg == $past(cnt_reg) + CNT_W'(1)
            || cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("Entry count changed by more than one in a cycle.");

endmodule

`default_nettype wire

// File: test/ordered_array_list_engine_test.sv
// Self-checking testbench for the ordered array list engine with a list predictor and random traffic.
`timescale 1ns / 1ps

module ordered_array_list_engine_test
    import oale_pkg::*;
();

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1325;
    localparam int CALM_TAIL = 200;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT = 400;
    localparam int STALL_LIMIT = 2000;
    localparam logic [2:0] M_SPARE_LO = 3'd6;
    localparam logic [2:0] M_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  position;
        logic [31:0] item_value;
    } list_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
        logic [7:0]  found_position;
        logic [5:0]  entry_total;
        logic        is_empty;
        logic        is_full;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    oale_req_if req_ch();
    oale_rsp_if rsp_ch();

    ordered_array_list_engine i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_req_t   pending_reqs[$];
    list_rsp_t   awaited_results[$];
    logic [31:0] list_words[$];
    int          total_items;
    int          gen_count;
    int          reqs_sent;
    int          rsps_taken;
    int          mismatches;
    bit          req_fired;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic list_rsp_t apply_list_op(input list_req_t r);
        list_rsp_t o;
        int        cnt;
        o = '0;
        o.status = ST_OK;
        cnt = list_words.size();
        case (r.mode)
            M_APPEND:
            begin
                if (cnt >= LIST_DEPTH)
                    o.status = ST_FULL;
                else
                    list_words.push_back(r.item_value);
            end
            M_INSERT:
            begin
                if (cnt >= LIST_DEPTH)
                    o.status = ST_FULL;
                else if (r.position > cnt)
                    o.status = ST_INVALID;
                else
                    list_words.insert(r.position, r.item_value);
            end
            M_EDIT:
            begin
                if (r.position >= cnt)
                    o.status = ST_INVALID;
                else
                    list_words[r.position] = r.item_value;
            end
            M_DELETE:
            begin
                if (cnt == 0)
                    o.status = ST_EMPTY;
                else if (r.position >= cnt)
                    o.status = ST_INVALID;
                else
                    list_words.delete(r.position);
            end
            M_READ:
            begin
                if (r.position >= cnt)
                    o.status = ST_INVALID;
                else
                    o.read_value = list_words[r.position];
            end
            M_FIND:
            begin
                o.status = ST_NOT_FOUND;
                for (int i = 0; i < cnt; i++)
                begin
                    if (list_words[i] == r.item_value)
                    begin
                        o.status = ST_OK;
                        o.found_position = i[7:0];
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        cnt = list_words.size();
        o.entry_total = cnt[5:0];
        o.is_empty = (cnt == 0);
        o.is_full = (cnt >= LIST_DEPTH);
        return o;
    endfunction

    task automatic queue_req(input logic [2:0] m, input logic [7:0] p, input logic [31:0] v);
        list_req_t r;
        r.mode = m;
        r.position = p;
        r.item_value = v;
        pending_reqs.push_back(r);
        // Track only the count so that random positions can aim at the live range.
        if (m == M_APPEND && gen_count < LIST_DEPTH)
            gen_count++;
        else if (m == M_INSERT && gen_count < LIST_DEPTH && p <= gen_count)
            gen_count++;
        else if (m == M_DELETE && gen_count > 0 && p < gen_count)
            gen_count--;
    endtask

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    initial
    begin
        logic [2:0]  m;
        logic [7:0]  p;
        logic [31:0] v;
        int          pick;
        int          span;
        bit          growing;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = '0;
        req_ch.position = '0;
        req_ch.item_value = '0;
        rsp_ch.ready = 1'b0;
        gen_count = 0;
        growing = 1'b0;

        queue_req(M_READ, 8'd0, 32'h0);
        queue_req(M_EDIT, 8'd0, 32'h1);
        queue_req(M_DELETE, 8'd0, 32'h0);
        queue_req(M_FIND, 8'd0, 32'h0);
        queue_req(M_INSERT, 8'd1, 32'h2);
        queue_req(M_INSERT, 8'd0, 32'h0000_0000);
        queue_req(M_APPEND, 8'd255, 32'hFFFF_FFFF);
        queue_req(M_INSERT, 8'd2, 32'h1234_5678);
        queue_req(M_INSERT, 8'd1, 32'h8000_0001);
        queue_req(M_INSERT, 8'd255, 32'h3);
        queue_req(M_EDIT, 8'd3, 32'hAAAA_AAAA);
        queue_req(M_EDIT, 8'd4, 32'h5555_5555);
        queue_req(M_READ, 8'd0, 32'h0);
        queue_req(M_READ, 8'd3, 32'h0);
        queue_req(M_READ, 8'd4, 32'h0);
        queue_req(M_READ, 8'd255, 32'hFFFF_FFFF);
        queue_req(M_FIND, 8'd0, 32'hFFFF_FFFF);
        queue_req(M_FIND, 8'd0, 32'h5555_5555);
        queue_req(M_DELETE, 8'd255, 32'h0);
        queue_req(M_DELETE, 8'd4, 32'h0);
        queue_req(M_DELETE, 8'd3, 32'h0);
        queue_req(M_DELETE, 8'd0, 32'h0);
        queue_req(M_SPARE_LO, 8'd255, 32'hFFFF_FFFF);
        queue_req(M_SPARE_HI, 8'd0, 32'h0);
        queue_req(M_DELETE, 8'd0, 32'h0);
        queue_req(M_DELETE, 8'd0, 32'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Alternate between filling phases and draining phases so both full and empty recur.
            if (n % 110 == 0)
                growing = !growing;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                m = (pick == 0) ? M_SPARE_HI : M_SPARE_LO;
            else if (growing)
                m = (pick < 30) ? M_APPEND : (pick < 55) ? M_INSERT : (pick < 65) ? M_DELETE :
                    (pick < 75) ? M_EDIT : (pick < 87) ? M_READ : M_FIND;
            else
                m = (pick < 8) ? M_APPEND : (pick < 18) ? M_INSERT : (pick < 55) ? M_DELETE :
                    (pick < 67) ? M_EDIT : (pick < 83) ? M_READ : M_FIND;
            span = (m == M_INSERT) ? gen_count : gen_count - 1;
            pick = $urandom_range(0, 99);
            if (pick < 80 && span >= 0)
                p = 8'($urandom_range(0, span));
            else if (pick < 90)
                p = 8'(gen_count + $urandom_range(0, 1));
            else
                p = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1)
                v = $urandom_range(0, 15) * 32'h1111_1111;
            else
                v = $urandom;
            queue_req(m, p, v);
        end
        total_items = pending_reqs.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (reqs_sent == total_items);
        wait (awaited_results.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    always @(negedge clk)
    begin : driver
        int  gap_left;
        bit  calm;
        if (rst_n)
        begin
            calm = (reqs_sent >= total_items - CALM_TAIL);
            if (!req_ch.valid || req_fired)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                begin
                    req_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 4) == 0)
                begin
                    gap_left = $urandom_range(1, 7) - 1;
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.mode <= pending_reqs[0].mode;
                    req_ch.position <= pending_reqs[0].position;
                    req_ch.item_value <= pending_reqs[0].item_value;
                    void'(pending_reqs.pop_front());
                end
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        int stall_left;
        int hold_left;
        bit hold_done;
        if (rst_n)
        begin
            if (!hold_done && rsps_taken >= HOLD_OFF_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsps_taken < total_items - CALM_TAIL && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        list_req_t r;
        list_rsp_t want;
        req_fired = 1'b0;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsps_taken++;
                if (awaited_results.size() == 0)
                begin
                    $error("Response transaction arrived with no request outstanding.");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, rsp_ch.status);
                    check_field("read_value", want.read_value, rsp_ch.read_value);
                    check_field("found_position", want.found_position, rsp_ch.found_position);
                    check_field("entry_total", want.entry_total, rsp_ch.entry_total);
                    check_field("is_empty", want.is_empty, rsp_ch.is_empty);
                    check_field("is_full", want.is_full, rsp_ch.is_full);
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                r.mode = req_ch.mode;
                r.position = req_ch.position;
                r.item_value = req_ch.item_value;
                awaited_results.push_back(apply_list_op(r));
                reqs_sent++;
                req_fired = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
